FILE: hdl/sth_pkg.sv
// Package for the star tracker sample-and-hold block.
// Holds shared constants, the configuration register indices and the back-end state enum. No dependencies.
package sth_pkg;

	localparam int NUM_TRACKERS_DEF = 3;
	localparam int COMP_WIDTH_DEF   = 16;
	localparam int TIME_WIDTH_DEF   = 32;
	localparam int SLOT_BITS        = 16;
	localparam int CFG_IDX_WIDTH    = 3;
	localparam int CFG_DATA_WIDTH   = 64;
	localparam int MAX_TRACKERS     = 3;

	localparam logic [CFG_IDX_WIDTH-1:0] REG_ERR_A = 3'd0;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ERR_B = 3'd1;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_ERR_C = 3'd2;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PER_A = 3'd3;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PER_B = 3'd4;
	localparam logic [CFG_IDX_WIDTH-1:0] REG_PER_C = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_MOD_PH,
		ST_MOD_ST,
		ST_MUL,
		ST_FIN,
		ST_OUT
	} be_state_t;

endpackage

FILE: hdl/sth_queue.sv
// Two-entry request queue between the front end and the back end.
// Generic width; uses no package items.
module sth_queue #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [WIDTH-1:0] in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [WIDTH-1:0] out_data
);

	logic [WIDTH-1:0] mem_q [2];
	logic             wr_q;
	logic             rd_q;
	logic [1:0]       cnt_q;
	logic             push;
	logic             pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = mem_q[rd_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

FILE: hdl/sth_divider.sv
// Restoring remainder unit: one quotient bit per cycle.
// Generic width; uses no package items.
module sth_divider #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             done,
	output logic [WIDTH-1:0] remainder
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] num_q;
	logic [WIDTH-1:0] den_q;
	logic [WIDTH:0]   rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH:0]   diff;

	assign shifted   = {rem_q[WIDTH-1:0], num_q[WIDTH-1]};
	assign diff      = shifted - {1'b0, den_q};
	assign remainder = rem_q[WIDTH-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(WIDTH);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[WIDTH-2:0], 1'b0};
			rem_q <= diff[WIDTH] ? shifted : diff;
		end
	end

endmodule

FILE: hdl/sth_back.sv
// Back end: per tracker phase reduction, refresh decision, Hamilton product and result output.
// Depends on sth_pkg and sth_divider.
module sth_back #(
	parameter int NUM_TRACKERS = sth_pkg::NUM_TRACKERS_DEF,
	parameter int COMP_WIDTH   = sth_pkg::COMP_WIDTH_DEF,
	parameter int TIME_WIDTH   = sth_pkg::TIME_WIDTH_DEF
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         req_valid,
	output logic                                         req_ready,
	input  logic [4*COMP_WIDTH+TIME_WIDTH-1:0]           req_data,
	input  logic [sth_pkg::MAX_TRACKERS-1:0][63:0]       err_quat,
	input  logic [sth_pkg::MAX_TRACKERS-1:0][TIME_WIDTH-1:0] period,
	output logic                                         res_valid,
	input  logic                                         res_ready,
	output logic [1:0]                                   res_index,
	output logic [4*COMP_WIDTH-1:0]                      res_meas,
	output logic                                         res_refreshed,
	output logic                                         res_last
);

	localparam int FRAC   = COMP_WIDTH - 2;
	localparam int ELEM   = (COMP_WIDTH < 16) ? COMP_WIDTH : 16;
	localparam int PW     = 2 * COMP_WIDTH;
	localparam int AW     = PW + 3;
	localparam int TW     = TIME_WIDTH;

	sth_pkg::be_state_t state_q, state_d;

	logic signed [COMP_WIDTH-1:0] truth_q [4];
	logic [TW-1:0]                step_q;
	logic [1:0]                   trk_q;
	logic [3:0]                   term_q;
	logic [TW-1:0]                rem_ph_q;
	logic                         refr_q;
	logic signed [AW-1:0]         acc_q;
	logic signed [PW-1:0]         prod_s1;
	logic                         prod_neg_s1;
	logic                         prod_vld_s1;
	logic                         prod_last_s1;
	logic signed [COMP_WIDTH-1:0] held_q [sth_pkg::MAX_TRACKERS][4];
	logic [TW-1:0]                phase_q [sth_pkg::MAX_TRACKERS];

	logic                         div_start;
	logic [TW-1:0]                div_num;
	logic                         div_done;
	logic [TW-1:0]                div_rem;
	logic [TW-1:0]                per_cur;
	logic signed [COMP_WIDTH-1:0] err_e [4];
	logic [1:0]                   li, ri;
	logic                         neg;
	logic signed [AW-1:0]         rnd;
	logic signed [AW-1:0]         lim_hi, lim_lo;
	logic signed [COMP_WIDTH-1:0] sat;
	logic [TW-1:0]                gap;
	logic [TW-1:0]                new_ph;
	logic                         last_trk;

	assign per_cur  = period[trk_q];
	assign last_trk = (trk_q == 2'(NUM_TRACKERS - 1));

	always_comb begin
		for (int k = 0; k < 4; k++) begin
			err_e[k] = COMP_WIDTH'($signed(err_quat[trk_q][k*sth_pkg::SLOT_BITS +: ELEM]))
				<<< (COMP_WIDTH - ELEM);
		end
	end

	// Term table: left index into truth, right index into error, and sign.
	always_comb begin
		li = 2'd0; ri = 2'd0; neg = 1'b0;
		case (term_q)
			4'd0:  begin li = 2'd0; ri = 2'd0; neg = 1'b0; end
			4'd1:  begin li = 2'd1; ri = 2'd1; neg = 1'b1; end
			4'd2:  begin li = 2'd2; ri = 2'd2; neg = 1'b1; end
			4'd3:  begin li = 2'd3; ri = 2'd3; neg = 1'b1; end
			4'd4:  begin li = 2'd0; ri = 2'd1; neg = 1'b0; end
			4'd5:  begin li = 2'd1; ri = 2'd0; neg = 1'b0; end
			4'd6:  begin li = 2'd2; ri = 2'd3; neg = 1'b0; end
			4'd7:  begin li = 2'd3; ri = 2'd2; neg = 1'b1; end
			4'd8:  begin li = 2'd0; ri = 2'd2; neg = 1'b0; end
			4'd9:  begin li = 2'd2; ri = 2'd0; neg = 1'b0; end
			4'd10: begin li = 2'd3; ri = 2'd1; neg = 1'b0; end
			4'd11: begin li = 2'd1; ri = 2'd3; neg = 1'b1; end
			4'd12: begin li = 2'd0; ri = 2'd3; neg = 1'b0; end
			4'd13: begin li = 2'd3; ri = 2'd0; neg = 1'b0; end
			4'd14: begin li = 2'd1; ri = 2'd2; neg = 1'b0; end
			4'd15: begin li = 2'd2; ri = 2'd1; neg = 1'b1; end
			default: begin li = 2'd0; ri = 2'd0; neg = 1'b0; end
		endcase
	end

	// Round half up, then saturate.
	always_comb begin
		rnd    = (acc_q + (AW'(1) <<< (FRAC - 1))) >>> FRAC;
		lim_hi = (AW'(1) <<< (COMP_WIDTH - 1)) - AW'(1);
		lim_lo = -(AW'(1) <<< (COMP_WIDTH - 1));
		if (rnd > lim_hi) begin
			sat = COMP_WIDTH'(lim_hi);
		end else if (rnd < lim_lo) begin
			sat = COMP_WIDTH'(lim_lo);
		end else begin
			sat = COMP_WIDTH'(rnd);
		end
	end

	assign gap    = per_cur - div_rem;
	assign new_ph = (rem_ph_q >= gap) ? (rem_ph_q - gap) : (rem_ph_q + div_rem);
	assign div_num = (state_q == sth_pkg::ST_MOD_PH) ? step_q : phase_q[trk_q];

	sth_divider #(.WIDTH(TW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (div_num),
		.divisor   (per_cur),
		.done      (div_done),
		.remainder (div_rem)
	);

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		div_start = 1'b0;
		case (state_q)
			sth_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = sth_pkg::ST_LOAD;
				end
			end
			sth_pkg::ST_LOAD: begin
				if (per_cur == '0) begin
					state_d = sth_pkg::ST_OUT;
				end else begin
					div_start = 1'b1;
					state_d   = sth_pkg::ST_MOD_PH;
				end
			end
			sth_pkg::ST_MOD_PH: begin
				if (div_done) begin
					div_start = 1'b1;
					state_d   = sth_pkg::ST_MOD_ST;
				end
			end
			sth_pkg::ST_MOD_ST: begin
				if (div_done) begin
					state_d = refr_q ? sth_pkg::ST_MUL : sth_pkg::ST_OUT;
				end
			end
			sth_pkg::ST_MUL: begin
				if (prod_vld_s1 && prod_last_s1) begin
					state_d = sth_pkg::ST_FIN;
				end
			end
			sth_pkg::ST_FIN: begin
				state_d = sth_pkg::ST_OUT;
			end
			sth_pkg::ST_OUT: begin
				if (res_ready) begin
					state_d = last_trk ? sth_pkg::ST_IDLE : sth_pkg::ST_LOAD;
				end
			end
			default: state_d = sth_pkg::ST_IDLE;
		endcase
	end

	assign res_valid     = (state_q == sth_pkg::ST_OUT);
	assign res_index     = trk_q;
	assign res_last      = last_trk;
	assign res_refreshed = refr_q;
	assign res_meas      = {held_q[trk_q][3], held_q[trk_q][2], held_q[trk_q][1], held_q[trk_q][0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sth_pkg::ST_IDLE;
			trk_q       <= '0;
			prod_vld_s1 <= 1'b0;
			for (int t = 0; t < sth_pkg::MAX_TRACKERS; t++) begin
				phase_q[t] <= '0;
				held_q[t][0] <= COMP_WIDTH'(1) <<< FRAC;
				for (int k = 1; k < 4; k++) begin
					held_q[t][k] <= '0;
				end
			end
		end else begin
			state_q     <= state_d;
			prod_vld_s1 <= (state_q == sth_pkg::ST_MUL) && !(prod_vld_s1 && prod_last_s1);
			case (state_q)
				sth_pkg::ST_IDLE: begin
					trk_q <= '0;
				end
				sth_pkg::ST_MOD_ST: begin
					if (div_done) begin
						phase_q[trk_q] <= new_ph;
					end
				end
				sth_pkg::ST_FIN: begin
					held_q[trk_q][3] <= sat;
				end
				sth_pkg::ST_OUT: begin
					if (res_ready && !last_trk) begin
						trk_q <= trk_q + 2'd1;
					end
				end
				default: ;
			endcase
			if (state_q == sth_pkg::ST_MUL && prod_vld_s1 && term_q[1:0] == 2'd1
				&& term_q != 4'd1 && !prod_last_s1) begin
				held_q[trk_q][term_q[3:2] - 2'd1] <= sat;
			end
		end
	end

	// Payload: product pipeline and accumulator. A product leaves the multiplier
	// in the cycle after its term is issued; each group of four is summed exactly.
	always_ff @(posedge clk) begin
		if (state_q == sth_pkg::ST_IDLE && req_valid) begin
			for (int k = 0; k < 4; k++) begin
				truth_q[k] <= req_data[k*COMP_WIDTH +: COMP_WIDTH];
			end
			step_q <= req_data[4*COMP_WIDTH +: TW];
		end
		if (state_q == sth_pkg::ST_LOAD && per_cur == '0) begin
			refr_q <= 1'b0;
		end
		if (state_q == sth_pkg::ST_MOD_PH && div_done) begin
			rem_ph_q <= div_rem;
			refr_q   <= (step_q > div_rem);
		end
		if (state_q != sth_pkg::ST_MUL) begin
			term_q       <= '0;
			prod_last_s1 <= 1'b0;
			acc_q        <= '0;
		end else begin
			prod_s1      <= truth_q[li] * err_e[ri];
			prod_neg_s1  <= neg;
			prod_last_s1 <= (term_q == 4'd15) && prod_vld_s1;
			if (term_q != 4'd15) begin
				term_q <= term_q + 4'd1;
			end
			if (prod_vld_s1) begin
				if (term_q[1:0] == 2'd1 && term_q != 4'd1) begin
					acc_q <= prod_neg_s1 ? -AW'(prod_s1) : AW'(prod_s1);
				end else begin
					acc_q <= acc_q + (prod_neg_s1 ? -AW'(prod_s1) : AW'(prod_s1));
				end
			end else if (term_q == 4'd0) begin
				acc_q <= '0;
			end
		end
	end

endmodule

FILE: hdl/star_tracker_sample_hold_top.sv
// Top level of the star tracker sample-and-hold block.
// Depends on sth_pkg, sth_queue and sth_back.

// Three star trackers are modelled. Each accepted request carries a truth
// quaternion and a time step. For every tracker in turn the stored phase is
// reduced modulo the tracker's period, the step is reduced likewise, and when
// the step exceeds the reduced phase the held measurement becomes the Hamilton
// product of truth and the mounting error quaternion (Q1.14, rounded half up,
// saturated). One result per tracker is sent, tlast on the final one. A tracker
// with a non-zero period passes a set-up state, two reductions in the shared
// bit-serial remainder unit and an output state, plus a pass through the
// single shared multiplier when it refreshes; a tracker whose period is zero
// goes from set-up straight to output. The request is first taken from the
// queue in an idle state, and a result may wait for the receiver. A two-entry
// queue sits between the input front end and the back end, so requests are
// taken while results wait.
module star_tracker_sample_hold_top #(
	parameter int NUM_TRACKERS = sth_pkg::NUM_TRACKERS_DEF,
	parameter int COMP_WIDTH   = sth_pkg::COMP_WIDTH_DEF,
	parameter int TIME_WIDTH   = sth_pkg::TIME_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [sth_pkg::CFG_IDX_WIDTH-1:0]     cfg_index,
	input  logic [sth_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// truth_w, truth_x, truth_y, truth_z, step_ticks
	input  logic [((4*COMP_WIDTH+TIME_WIDTH+7)/8)*8-1:0] s_axis_tdata,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// tracker_index, meas_w, meas_x, meas_y, meas_z, refreshed
	output logic [((4*COMP_WIDTH+3+7)/8)*8-1:0]   m_axis_tdata,
	output logic                                  m_axis_tlast
);

	localparam int REQ_W = 4*COMP_WIDTH + TIME_WIDTH;
	localparam int OUT_W = ((4*COMP_WIDTH+3+7)/8)*8;

	logic [sth_pkg::MAX_TRACKERS-1:0][63:0]         err_q;
	logic [sth_pkg::MAX_TRACKERS-1:0][TIME_WIDTH-1:0] per_q;
	logic             q_valid, q_ready;
	logic [REQ_W-1:0] q_data;
	logic [1:0]       r_index;
	logic [4*COMP_WIDTH-1:0] r_meas;
	logic             r_refr;

	// Configuration registers; writes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q <= '0;
			per_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				sth_pkg::REG_ERR_A: err_q[0] <= cfg_data;
				sth_pkg::REG_ERR_B: err_q[1] <= cfg_data;
				sth_pkg::REG_ERR_C: err_q[2] <= cfg_data;
				sth_pkg::REG_PER_A: per_q[0] <= TIME_WIDTH'(cfg_data[31:0]);
				sth_pkg::REG_PER_B: per_q[1] <= TIME_WIDTH'(cfg_data[31:0]);
				sth_pkg::REG_PER_C: per_q[2] <= TIME_WIDTH'(cfg_data[31:0]);
				default: ;
			endcase
		end
	end

	sth_queue #(.WIDTH(REQ_W)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata[REQ_W-1:0]),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_data  (q_data)
	);

	sth_back #(
		.NUM_TRACKERS (NUM_TRACKERS),
		.COMP_WIDTH   (COMP_WIDTH),
		.TIME_WIDTH   (TIME_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (q_valid),
		.req_ready     (q_ready),
		.req_data      (q_data),
		.err_quat      (err_q),
		.period        (per_q),
		.res_valid     (m_axis_tvalid),
		.res_ready     (m_axis_tready),
		.res_index     (r_index),
		.res_meas      (r_meas),
		.res_refreshed (r_refr),
		.res_last      (m_axis_tlast)
	);

	assign m_axis_tdata = OUT_W'({r_refr, r_meas, r_index});

endmodule
